### sv/pitch_class_set_classifier_assert.svh
// Assertion macros used by the checker file.
`ifndef PITCH_CLASS_SET_CLASSIFIER_ASSERT_SVH
`define PITCH_CLASS_SET_CLASSIFIER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PCSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pitch class set classifier check failed");

// Antecedent implies consequent in the same cycle.
`define PCSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pitch class set classifier check failed");

`endif

### sv/pcsc_pkg.sv
package pcsc_pkg;

  localparam int unsigned PcCount = 12;
  localparam int unsigned CatN    = 135;

  typedef logic [11:0] tab_t [CatN];

  typedef struct packed {
    logic        ok;
    logic [3:0]  span;
    logic [11:0] t;
  } cand_t;

  // Catalogue entries, cardinality 2 through 6 in order.
  localparam tab_t CAT = '{
    12'h003, 12'h005, 12'h009, 12'h011, 12'h021, 12'h041,
    12'h007, 12'h00B, 12'h013, 12'h023, 12'h043, 12'h015, 12'h025, 12'h045,
    12'h085, 12'h049, 12'h089, 12'h111,
    12'h00F, 12'h017, 12'h01B, 12'h027, 12'h047, 12'h087, 12'h033, 12'h063,
    12'h0C3, 12'h02D, 12'h02B, 12'h04D, 12'h04B, 12'h08D, 12'h053, 12'h0A3,
    12'h099, 12'h093, 12'h113, 12'h123, 12'h055, 12'h095, 12'h0A5, 12'h115,
    12'h145, 12'h129, 12'h125, 12'h249, 12'h08B,
    12'h01F, 12'h02F, 12'h037, 12'h04F, 12'h08F, 12'h067, 12'h0C7, 12'h05D,
    12'h057, 12'h05B, 12'h09D, 12'h06B, 12'h117, 12'h0A7, 12'h147, 12'h09B,
    12'h11B, 12'h0B3, 12'h0CB, 12'h163, 12'h133, 12'h193, 12'h0AD, 12'h0AB,
    12'h12D, 12'h135, 12'h12B, 12'h14D, 12'h14B, 12'h153, 12'h24B, 12'h253,
    12'h155, 12'h255, 12'h295, 12'h097, 12'h139, 12'h127,
    12'h03F, 12'h05F, 12'h06F, 12'h077, 12'h0CF, 12'h0E7, 12'h1C7, 12'h0BD,
    12'h0AF, 12'h0BB, 12'h0B7, 12'h0D7, 12'h0DB, 12'h13B, 12'h137, 12'h173,
    12'h197, 12'h1A7, 12'h19B, 12'h333, 12'h15D, 12'h157, 12'h16D, 12'h15B,
    12'h16B, 12'h1AB, 12'h25B, 12'h26B, 12'h34B, 12'h2CB, 12'h32B, 12'h2B5,
    12'h2AD, 12'h2AB, 12'h555, 12'h09F, 12'h11F, 12'h18F, 12'h13D, 12'h12F,
    12'h14F, 12'h24F, 12'h167, 12'h267, 12'h25D, 12'h257, 12'h297, 12'h2A7,
    12'h29B, 12'h2D3
  };

  function automatic logic [3:0] popcnt(logic [11:0] m);
    logic [3:0] c;
    c = '0;
    for (int p = 0; p < PcCount; p++) c = c + {3'b000, m[p]};
    return c;
  endfunction

  function automatic logic [11:0] rot_down(logic [11:0] m, int r);
    logic [23:0] w;
    w = {m, m} >> r;
    return w[11:0];
  endfunction

  function automatic logic [3:0] top_pc(logic [11:0] m);
    logic [3:0] t;
    t = '0;
    for (int p = 0; p < PcCount; p++) if (m[p]) t = 4'(p);
    return t;
  endfunction

  function automatic logic lex_le(logic [11:0] a, logic [11:0] b);
    logic [11:0] d;
    logic [11:0] low;
    d   = a ^ b;
    low = d & (~d + 12'd1);
    return (d == '0) || ((a & low) != '0);
  endfunction

  function automatic logic [11:0] invert(logic [11:0] m);
    logic [11:0] r;
    r[0] = m[0];
    for (int j = 1; j < PcCount; j++) r[j] = m[PcCount - j];
    return r;
  endfunction

  function automatic cand_t better(cand_t a, cand_t b);
    if (a.ok && (!b.ok || a.span < b.span || (a.span == b.span && lex_le(a.t, b.t))))
      return a;
    return b;
  endfunction

  function automatic logic [11:0] nf_const(logic [11:0] m);
    cand_t best;
    cand_t c;
    best = '0;
    if (popcnt(m) <= 4'd1) return m;
    for (int r = 0; r < PcCount; r++) begin
      c.ok   = m[r];
      c.t    = rot_down(m, r);
      c.span = top_pc(c.t);
      best   = better(best, c);
    end
    return best.t;
  endfunction

  function automatic logic [11:0] pf_const(logic [11:0] m);
    logic [11:0] a;
    logic [11:0] b;
    a = nf_const(m);
    b = nf_const(invert(m));
    return lex_le(a, b) ? a : b;
  endfunction

  function automatic tab_t build_pf();
    tab_t t;
    for (int i = 0; i < CatN; i++) t[i] = pf_const(CAT[i]);
    return t;
  endfunction

  localparam tab_t CAT_PF = build_pf();

  function automatic logic [3:0] card_of(int i);
    if (i < 6) return 4'd2;
    if (i < 18) return 4'd3;
    if (i < 47) return 4'd4;
    if (i < 85) return 4'd5;
    return 4'd6;
  endfunction

  function automatic logic [5:0] ord_of(int i);
    if (i < 6) return 6'(i + 1);
    if (i < 18) return 6'(i - 5);
    if (i < 47) return 6'(i - 17);
    if (i < 85) return 6'(i - 46);
    return 6'(i - 84);
  endfunction

  function automatic logic z_of(int i);
    logic [5:0] o;
    o = ord_of(i);
    case (card_of(i))
      4'd4: return o == 6'd15 || o == 6'd29;
      4'd5: return o == 6'd12 || o == 6'd17 || o == 6'd18 || o >= 6'd36;
      4'd6: return o == 6'd3 || o == 6'd4 || o == 6'd6 || (o >= 6'd10 && o <= 6'd13) ||
                   o == 6'd17 || o == 6'd19 || (o >= 6'd23 && o <= 6'd26) ||
                   o == 6'd28 || o == 6'd29 || o >= 6'd36;
      default: return 1'b0;
    endcase
  endfunction

endpackage

### sv/pitch_class_set_classifier.sv
// Each start transfer yields one valid_o strobe.
// Throughput: one set per cycle; busy is always low.
// Seven register stages: masks, rotation tree (three levels), prime select,
// catalogue compare, ordinal encode.
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
module pitch_class_set_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] set_mask_i,
  output logic        valid_o,
  output logic [3:0]  cardinality_o,
  output logic [11:0] normal_form_mask_o,
  output logic [11:0] prime_form_mask_o,
  output logic [5:0]  class_ordinal_o,
  output logic        z_marked_o,
  output logic        found_o
);

  // valid bits of stages 1..7
  logic [6:0] v_q, v_d;

  // stage 1: four masks (set, inversion, complement, its inversion)
  logic [11:0] m1_q [4];
  logic [3:0]  c1_q;
  // stages 2..4: rotation tree
  pcsc_pkg::cand_t t2_q [4][6];
  pcsc_pkg::cand_t t3_q [4][3];
  logic [3:0]  c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [11:0] m2_q [4];
  logic [11:0] m3_q [4];
  logic [11:0] nf4_q [4];
  // stage 5: forms and key
  logic [11:0] nf5_q, pf5_q, key5_q;
  logic [3:0]  lc5_q;
  // stage 6: catalogue match
  logic [pcsc_pkg::CatN-1:0] match6_q;
  logic [11:0] nf6_q, pf6_q;
  logic        spec6_q;

  assign busy = 1'b0;
  assign v_d  = {v_q[5:0], start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [11:0] cm;
    pcsc_pkg::cand_t ca, cb;
    pcsc_pkg::cand_t x;
    logic raw_pick;
    logic [11:0] pa, pb;
    cm = ~set_mask_i;
    // stage 1
    m1_q[0] <= set_mask_i;
    m1_q[1] <= pcsc_pkg::invert(set_mask_i);
    m1_q[2] <= cm;
    m1_q[3] <= pcsc_pkg::invert(cm);
    c1_q    <= pcsc_pkg::popcnt(set_mask_i);
    // stage 2: candidates, first reduction level
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 6; j++) begin
        ca.ok   = m1_q[k][2*j];
        ca.t    = pcsc_pkg::rot_down(m1_q[k], 2*j);
        ca.span = pcsc_pkg::top_pc(ca.t);
        cb.ok   = m1_q[k][2*j+1];
        cb.t    = pcsc_pkg::rot_down(m1_q[k], 2*j+1);
        cb.span = pcsc_pkg::top_pc(cb.t);
        t2_q[k][j] <= pcsc_pkg::better(ca, cb);
      end
      m2_q[k] <= m1_q[k];
    end
    c2_q <= c1_q;
    // stage 3
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        t3_q[k][j] <= pcsc_pkg::better(t2_q[k][2*j], t2_q[k][2*j+1]);
      end
      m3_q[k] <= m2_q[k];
    end
    c3_q <= c2_q;
    // stage 4: final pick; empty and single-member sets stay untransposed
    for (int k = 0; k < 4; k++) begin
      x = pcsc_pkg::better(pcsc_pkg::better(t3_q[k][0], t3_q[k][1]), t3_q[k][2]);
      raw_pick = (k < 2) ? (c3_q <= 4'd1) : (c3_q >= 4'd11);
      nf4_q[k] <= raw_pick ? m3_q[k] : x.t;
    end
    c4_q <= c3_q;
    // stage 5: prime forms and lookup key
    pa = pcsc_pkg::lex_le(nf4_q[0], nf4_q[1]) ? nf4_q[0] : nf4_q[1];
    pb = pcsc_pkg::lex_le(nf4_q[2], nf4_q[3]) ? nf4_q[2] : nf4_q[3];
    nf5_q  <= nf4_q[0];
    pf5_q  <= pa;
    key5_q <= (c4_q >= 4'd7) ? pb : pa;
    lc5_q  <= (c4_q >= 4'd7) ? 4'd12 - c4_q : c4_q;
    c5_q   <= c4_q;
    // stage 6: compare against every catalogue prime form
    for (int i = 0; i < pcsc_pkg::CatN; i++) begin
      match6_q[i] <= (pcsc_pkg::CAT_PF[i] == key5_q) && (pcsc_pkg::card_of(i) == lc5_q);
    end
    nf6_q   <= nf5_q;
    pf6_q   <= pf5_q;
    c6_q    <= c5_q;
    spec6_q <= (c5_q <= 4'd1) || (c5_q >= 4'd11);
  end

  // stage 7: encode the first matching entry
  logic [5:0] ord_d;
  logic       z_d;
  logic       hit_d;

  always_comb begin
    ord_d = '0;
    z_d   = 1'b0;
    for (int i = pcsc_pkg::CatN - 1; i >= 0; i--) begin
      if (match6_q[i]) begin
        ord_d = pcsc_pkg::ord_of(i);
        z_d   = pcsc_pkg::z_of(i);
      end
    end
    hit_d = |match6_q;
  end

  always_ff @(posedge clk_i) begin
    cardinality_o      <= c6_q;
    normal_form_mask_o <= nf6_q;
    prime_form_mask_o  <= pf6_q;
    class_ordinal_o    <= spec6_q ? 6'd1 : ord_d;
    z_marked_o         <= spec6_q ? 1'b0 : z_d;
    found_o            <= spec6_q | hit_d;
  end

  assign valid_o = v_q[6];

endmodule

### sv/pcsc_checker.sv
`include "pitch_class_set_classifier_assert.svh"

module pcsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        valid_o,
  input logic [3:0]  cardinality_o,
  input logic [11:0] normal_form_mask_o,
  input logic [11:0] prime_form_mask_o,
  input logic [5:0]  class_ordinal_o,
  input logic        found_o
);

  `PCSC_ASSERT(a_never_busy, clk_i, rst_ni, !busy)
  `PCSC_ASSERT_IMP(a_card_range, clk_i, rst_ni, valid_o, cardinality_o <= 4'd12)
  `PCSC_ASSERT_IMP(a_forms_size, clk_i, rst_ni, valid_o,
    $countones(normal_form_mask_o) == cardinality_o &&
    $countones(prime_form_mask_o) == cardinality_o)
  `PCSC_ASSERT_IMP(a_found_ord, clk_i, rst_ni, valid_o, found_o == (class_ordinal_o != 6'd0))

endmodule

bind pitch_class_set_classifier pcsc_checker u_pcsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .busy               (busy),
  .valid_o            (valid_o),
  .cardinality_o      (cardinality_o),
  .normal_form_mask_o (normal_form_mask_o),
  .prime_form_mask_o  (prime_form_mask_o),
  .class_ordinal_o    (class_ordinal_o),
  .found_o            (found_o)
);

### dv/tb_pitch_class_set_classifier.sv
`timescale 1ns / 100ps

module tb_pitch_class_set_classifier;

  typedef struct packed {
    logic [3:0]  card;
    logic [11:0] nf;
    logic [11:0] pf;
    logic [5:0]  ord;
    logic        z;
    logic        found;
  } class_res_t;

  localparam int LatencyCycles = 7;
  localparam int WatchdogLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [11:0] set_mask_i;
  logic        valid_o;
  logic [3:0]  cardinality_o;
  logic [11:0] normal_form_mask_o;
  logic [11:0] prime_form_mask_o;
  logic [5:0]  class_ordinal_o;
  logic        z_marked_o;
  logic        found_o;

  class_res_t expected_q[$];
  int         fail_count = 0;
  int         idle_cycles = 0;

  // Canonical catalogue, cardinality 2 through 6.
  logic [11:0] cat_entries [135] = '{
    12'h003, 12'h005, 12'h009, 12'h011, 12'h021, 12'h041,
    12'h007, 12'h00B, 12'h013, 12'h023, 12'h043, 12'h015, 12'h025, 12'h045,
    12'h085, 12'h049, 12'h089, 12'h111,
    12'h00F, 12'h017, 12'h01B, 12'h027, 12'h047, 12'h087, 12'h033, 12'h063,
    12'h0C3, 12'h02D, 12'h02B, 12'h04D, 12'h04B, 12'h08D, 12'h053, 12'h0A3,
    12'h099, 12'h093, 12'h113, 12'h123, 12'h055, 12'h095, 12'h0A5, 12'h115,
    12'h145, 12'h129, 12'h125, 12'h249, 12'h08B,
    12'h01F, 12'h02F, 12'h037, 12'h04F, 12'h08F, 12'h067, 12'h0C7, 12'h05D,
    12'h057, 12'h05B, 12'h09D, 12'h06B, 12'h117, 12'h0A7, 12'h147, 12'h09B,
    12'h11B, 12'h0B3, 12'h0CB, 12'h163, 12'h133, 12'h193, 12'h0AD, 12'h0AB,
    12'h12D, 12'h135, 12'h12B, 12'h14D, 12'h14B, 12'h153, 12'h24B, 12'h253,
    12'h155, 12'h255, 12'h295, 12'h097, 12'h139, 12'h127,
    12'h03F, 12'h05F, 12'h06F, 12'h077, 12'h0CF, 12'h0E7, 12'h1C7, 12'h0BD,
    12'h0AF, 12'h0BB, 12'h0B7, 12'h0D7, 12'h0DB, 12'h13B, 12'h137, 12'h173,
    12'h197, 12'h1A7, 12'h19B, 12'h333, 12'h15D, 12'h157, 12'h16D, 12'h15B,
    12'h16B, 12'h1AB, 12'h25B, 12'h26B, 12'h34B, 12'h2CB, 12'h32B, 12'h2B5,
    12'h2AD, 12'h2AB, 12'h555, 12'h09F, 12'h11F, 12'h18F, 12'h13D, 12'h12F,
    12'h14F, 12'h24F, 12'h167, 12'h267, 12'h25D, 12'h257, 12'h297, 12'h2A7,
    12'h29B, 12'h2D3
  };
  int          cat_base [2:6] = '{0, 6, 18, 47, 85};
  int          cat_len  [2:6] = '{6, 12, 29, 38, 50};

  pitch_class_set_classifier u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .set_mask_i         (set_mask_i),
    .valid_o            (valid_o),
    .cardinality_o      (cardinality_o),
    .normal_form_mask_o (normal_form_mask_o),
    .prime_form_mask_o  (prime_form_mask_o),
    .class_ordinal_o    (class_ordinal_o),
    .z_marked_o         (z_marked_o),
    .found_o            (found_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int member_count(logic [11:0] m);
    int c;
    c = 0;
    for (int p = 0; p < 12; p++) c += m[p];
    return c;
  endfunction

  // True when the ascending list of a sorts at or before that of b.
  function automatic bit sorts_first(logic [11:0] a, logic [11:0] b);
    for (int p = 0; p < 12; p++)
      if (a[p] != b[p]) return a[p];
    return 1'b1;
  endfunction

  function automatic logic [11:0] compact_rotation(logic [11:0] m);
    logic [11:0] best;
    logic [11:0] t;
    int          tight_span;
    int          s;
    best = '0;
    tight_span = 12;
    if (member_count(m) <= 1) return m;
    for (int r = 0; r < 12; r++) begin
      if (m[r]) begin
        for (int p = 0; p < 12; p++) t[p] = m[(p + r) % 12];
        s = 0;
        for (int p = 0; p < 12; p++) if (t[p]) s = p;
        if (s < tight_span || (s == tight_span && sorts_first(t, best))) begin
          tight_span = s;
          best = t;
        end
      end
    end
    return best;
  endfunction

  function automatic logic [11:0] mirror_set(logic [11:0] m);
    logic [11:0] r;
    for (int p = 0; p < 12; p++) r[(12 - p) % 12] = m[p];
    return r;
  endfunction

  function automatic logic [11:0] reduced_form(logic [11:0] m);
    logic [11:0] a;
    logic [11:0] b;
    a = compact_rotation(m);
    b = compact_rotation(mirror_set(m));
    return sorts_first(a, b) ? a : b;
  endfunction

  function automatic bit is_z_class(int card, int ord);
    case (card)
      4: return ord == 15 || ord == 29;
      5: return ord == 12 || ord == 17 || ord == 18 || ord >= 36;
      6: return ord inside {3, 4, 6, 10, 11, 12, 13, 17, 19, 23, 24, 25, 26, 28, 29}
                || ord >= 36;
      default: return 1'b0;
    endcase
  endfunction

  function automatic class_res_t classify(logic [11:0] m);
    class_res_t res;
    int         lc;
    logic [11:0] key;
    res = '0;
    res.card = 4'(member_count(m));
    res.nf = compact_rotation(m);
    res.pf = reduced_form(m);
    if (res.card <= 1 || res.card >= 11) begin
      res.ord = 6'd1;
      res.found = 1'b1;
    end else begin
      lc = res.card;
      key = res.pf;
      if (lc >= 7) begin
        lc = 12 - lc;
        key = reduced_form(~m);
      end
      for (int i = 0; i < cat_len[lc]; i++) begin
        if (res.found == 1'b0 && reduced_form(cat_entries[cat_base[lc] + i]) == key) begin
          res.ord = 6'(i + 1);
          res.found = 1'b1;
          res.z = is_z_class(lc, i + 1);
        end
      end
    end
    return res;
  endfunction

  // Checker: one strobe, one result, compared against the oldest expectation.
  always @(posedge clk_i) begin
    class_res_t got;
    class_res_t exp_res;
    if (rst_ni && valid_o) begin
      got = '{cardinality_o, normal_form_mask_o, prime_form_mask_o,
              class_ordinal_o, z_marked_o, found_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (got.card !== exp_res.card) begin
          $display("%0t: cardinality expected %0d actual %0d", $time, exp_res.card, got.card);
          fail_count++;
        end
        if (got.nf !== exp_res.nf) begin
          $display("%0t: normal form expected %h actual %h", $time, exp_res.nf, got.nf);
          fail_count++;
        end
        if (got.pf !== exp_res.pf) begin
          $display("%0t: prime form expected %h actual %h", $time, exp_res.pf, got.pf);
          fail_count++;
        end
        if (got.ord !== exp_res.ord) begin
          $display("%0t: ordinal expected %0d actual %0d", $time, exp_res.ord, got.ord);
          fail_count++;
        end
        if (got.z !== exp_res.z) begin
          $display("%0t: z flag expected %b actual %b", $time, exp_res.z, got.z);
          fail_count++;
        end
        if (got.found !== exp_res.found) begin
          $display("%0t: found expected %b actual %b", $time, exp_res.found, got.found);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_set(logic [11:0] m);
    start <= 1'b1;
    set_mask_i <= m;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.insert(expected_q.size(), classify(m));
  endtask

  task automatic go_idle(int n);
    start <= 1'b0;
    set_mask_i <= 12'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    go_idle(1);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_set(12'h000);
    send_set(12'hFFF);
    send_set(12'h001);
    send_set(12'h800);
    send_set(12'h020);
    send_set(12'h7FF);
    send_set(12'hFFE);
    send_set(12'h555);
    send_set(12'hAAA);
    send_set(12'h249);
    send_set(12'h111);
    send_set(12'h34B);
    send_set(12'h32B);
    send_set(12'h0A9);
    send_set(12'hCB4);
    send_set(12'h0FF);
    send_set(12'h3FF);
    send_set(12'hF00);
    send_set(12'h895);
    send_set(12'h003);
    drain();
  endtask

  // Every catalogue entry, transposed and sometimes inverted or complemented.
  task automatic test_catalogue();
    logic [11:0] m;
    int          r;
    for (int i = 0; i < 135; i++) begin
      r = $urandom_range(0, 11);
      m = 12'(({cat_entries[i], cat_entries[i]} << r) >> 12);
      if ($urandom_range(0, 1)) m = mirror_set(m);
      if ($urandom_range(0, 1)) m = ~m;
      send_set(m);
    end
    drain();
  endtask

  task automatic test_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n > 0; k++, n--) send_set(12'($urandom));
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 6));
    end
    drain();
  endtask

  initial begin
    start <= 1'b0;
    set_mask_i <= '0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_catalogue();
    test_random(1850);
    repeat (LatencyCycles + 3) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
